FILE: src/hst_pkg.sv
// shared constants, types and codes for the handle slot table
package hst_pkg;

  localparam int SLOTS       = 1024;
  localparam int SLOT_BITS   = $clog2(SLOTS);
  localparam int HANDLE_BITS = 24;
  localparam int HARBOR_BITS = 8;
  localparam int WORD_BITS   = 32;
  localparam int COUNT_BITS  = 11;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [SLOT_BITS-1:0]  SLOT_LAST = SLOT_BITS'(SLOTS - 1);
  localparam logic [HANDLE_BITS-1:0] HANDLE_RESET = HANDLE_BITS'(1);

  localparam logic [1:0] OP_REGISTER   = 2'd0;
  localparam logic [1:0] OP_RETIRE     = 2'd1;
  localparam logic [1:0] OP_GRAB       = 2'd2;
  localparam logic [1:0] OP_RETIRE_ALL = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic                   valid;
    logic [HANDLE_BITS-1:0] handle;
    logic [WORD_BITS-1:0]   payload;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic capture;  // latch request word, restart scan
    logic check;    // evaluate the slot that was read
    logic sweep;    // clear slot at pointer, advance pointer
    logic finish;   // load result registers, pulse done
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       free;        // probed slot is empty
    logic       probe_last;  // all other slots were found occupied
    logic       ptr_last;    // sweep pointer at last slot
  } sts_t;

endpackage

FILE: src/hst_ctrl.sv
// sequencer for scans, lookups and clearing sweeps
module hst_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  hst_pkg::sts_t sts,
  output hst_pkg::cmd_t cmd
);
  import hst_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_SWEEP = 3'd4;
  localparam logic [2:0] S_TAIL  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.sweep = 1'b1;
        if (sts.ptr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = S_READ;
        end
      end
      S_READ: begin
        state_next = (sts.op == OP_RETIRE_ALL) ? S_SWEEP : S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (sts.op == OP_REGISTER && !sts.free && !sts.probe_last) begin
          state_next = S_READ;
        end else begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.ptr_last) state_next = S_TAIL;
      end
      S_TAIL: begin
        // last slot's read data is tallied here
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: src/hst_dpath.sv
// slot memory, scan counters, harbor register and result registers
module hst_dpath (
  input  logic                             clk,
  input  logic                             rst,
  input  hst_pkg::cmd_t                    cmd,
  output hst_pkg::sts_t                    sts,
  input  logic                             harbor_id_wr,
  input  logic [hst_pkg::HARBOR_BITS-1:0]  harbor_id,
  input  logic [1:0]                       operation,
  input  logic [hst_pkg::WORD_BITS-1:0]    handle_in,
  input  logic [hst_pkg::WORD_BITS-1:0]    payload_in,
  output logic                             done,
  output logic [1:0]                       status,
  output logic [hst_pkg::WORD_BITS-1:0]    handle_out,
  output logic [hst_pkg::WORD_BITS-1:0]    payload_out,
  output logic [hst_pkg::COUNT_BITS-1:0]   retired_count
);
  import hst_pkg::*;

  entry_t mem [SLOTS];
  entry_t rdata;

  logic [HARBOR_BITS-1:0] harbor;
  logic [1:0]             op;
  logic [WORD_BITS-1:0]   handle_req;
  logic [WORD_BITS-1:0]   payload_req;
  logic [HANDLE_BITS-1:0] next_handle;
  logic [HANDLE_BITS-1:0] cand;
  logic [SLOT_BITS-1:0]   probes;
  logic [SLOT_BITS-1:0]   ptr;
  logic                   sweep_d;
  logic [COUNT_BITS-1:0]  count;
  logic [COUNT_BITS-1:0]  count_next;

  logic [SLOT_BITS-1:0] raddr;
  logic [SLOT_BITS-1:0] waddr;
  entry_t               wdata;
  logic                 we;
  logic                 free;
  logic                 match;

  assign free  = !rdata.valid;
  assign match = rdata.valid && ({harbor, rdata.handle} == handle_req);

  always_comb begin
    if (cmd.sweep) begin
      raddr = ptr;
    end else if (op == OP_REGISTER) begin
      raddr = cand[SLOT_BITS-1:0];
    end else begin
      raddr = handle_req[SLOT_BITS-1:0];
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = raddr;
    wdata = '0;
    if (cmd.sweep) begin
      we = 1'b1;
    end else if (cmd.check) begin
      if (op == OP_REGISTER && free) begin
        we    = 1'b1;
        wdata = '{valid: 1'b1, handle: cand, payload: payload_req};
      end else if (op == OP_RETIRE && match) begin
        we          = 1'b1;
        wdata       = rdata;
        wdata.valid = 1'b0;
      end
    end
  end

  // read returns the old word when the same slot is written
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // the tally follows the sweep in the next cycle because of the registered read
  always_comb begin
    count_next = count;
    if (sweep_d && rdata.valid && count != COUNT_MAX) begin
      count_next = count + COUNT_BITS'(1);
    end
  end

  assign sts.op         = op;
  assign sts.free       = free;
  assign sts.probe_last = (probes == SLOT_LAST);
  assign sts.ptr_last   = (ptr == SLOT_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      harbor      <= '0;
      next_handle <= HANDLE_RESET;
      ptr         <= '0;
      sweep_d     <= 1'b0;
      done        <= 1'b0;
    end else begin
      if (harbor_id_wr) harbor <= harbor_id;
      if (cmd.sweep) ptr <= ptr + SLOT_BITS'(1);
      sweep_d <= cmd.sweep;
      done    <= cmd.finish;
      if (cmd.check && op == OP_REGISTER && free) begin
        next_handle <= cand + HANDLE_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op          <= operation;
      handle_req  <= handle_in;
      payload_req <= payload_in;
      cand        <= next_handle;
      probes      <= '0;
      count       <= '0;
    end else begin
      count <= count_next;
      if (cmd.check && !free) begin
        cand   <= cand + HANDLE_BITS'(1);
        probes <= probes + SLOT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status        <= ST_OK;
      handle_out    <= '0;
      payload_out   <= '0;
      retired_count <= '0;
      case (op)
        OP_REGISTER: begin
          if (free) begin
            handle_out <= {harbor, cand};
          end else begin
            status <= ST_FULL;
          end
        end
        OP_RETIRE, OP_GRAB: begin
          if (match) begin
            payload_out <= rdata.payload;
          end else begin
            status <= ST_NOT_FOUND;
          end
        end
        OP_RETIRE_ALL: retired_count <= count_next;
        default: status <= ST_OK;
      endcase
    end
  end

endmodule

FILE: src/handle_slot_table.sv
// handle slot table top level: direct-mapped handle to payload table
// register checks candidate slots in turn until one is free or every slot was probed;
//   retire and grab read and check one slot; retire_all sweeps one slot per cycle
// one word at a time; the slot memory's single read and write port sets the pace
// reset: synchronous, active high; a clearing pass over every slot follows with busy high
// results appear for one cycle on done; the receiver cannot stall
module handle_slot_table (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             harbor_id_wr,
  input  logic [hst_pkg::HARBOR_BITS-1:0]  harbor_id,
  input  logic [1:0]                       operation,
  input  logic [hst_pkg::WORD_BITS-1:0]    handle_in,
  input  logic [hst_pkg::WORD_BITS-1:0]    payload_in,
  output logic                             done,
  output logic [1:0]                       status,
  output logic [hst_pkg::WORD_BITS-1:0]    handle_out,
  output logic [hst_pkg::WORD_BITS-1:0]    payload_out,
  output logic [hst_pkg::COUNT_BITS-1:0]   retired_count
);
  import hst_pkg::*;

  cmd_t cmd;
  sts_t sts;

  hst_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  hst_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .harbor_id_wr  (harbor_id_wr),
    .harbor_id     (harbor_id),
    .operation     (operation),
    .handle_in     (handle_in),
    .payload_in    (payload_in),
    .done          (done),
    .status        (status),
    .handle_out    (handle_out),
    .payload_out   (payload_out),
    .retired_count (retired_count)
  );

endmodule

FILE: tb/tb_handle_slot_table.sv
// testbench for the handle slot table: random and directed requests checked against a shadow table
module tb_handle_slot_table;
  timeunit 1ns;
  timeprecision 1ps;

  import hst_pkg::*;

  typedef struct {
    logic [1:0]            status;
    logic [WORD_BITS-1:0]  handle;
    logic [WORD_BITS-1:0]  payload;
    logic [COUNT_BITS-1:0] count;
  } reply_t;

  // shadow copy of the slot table, advanced when a request word is accepted
  class handle_table_shadow;
    bit                     used [SLOTS];
    logic [HANDLE_BITS-1:0] stored_handle [SLOTS];
    logic [WORD_BITS-1:0]   stored_payload [SLOTS];
    logic [HANDLE_BITS-1:0] next_handle;
    logic [HARBOR_BITS-1:0] harbor;
    int                     occupied;
    reply_t                 replies_due [$];
    int                     errors;
    int                     checked;
    int                     op_count [4];
    int                     full_count;
    int                     miss_count;

    function new();
      foreach (used[i]) used[i] = 1'b0;
      next_handle = HANDLE_RESET;
      harbor = '0;
      occupied = 0;
      errors = 0;
      checked = 0;
      full_count = 0;
      miss_count = 0;
      foreach (op_count[i]) op_count[i] = 0;
    endfunction

    function void load_harbor(logic [HARBOR_BITS-1:0] v);
      harbor = v;
    endfunction

    function void accept_request(logic [1:0] op, logic [WORD_BITS-1:0] h,
                                 logic [WORD_BITS-1:0] pay);
      reply_t                 r;
      logic [HANDLE_BITS-1:0] cand;
      int                     idx;
      int                     i;
      r.status = ST_OK;
      r.handle = '0;
      r.payload = '0;
      r.count = '0;
      op_count[op]++;
      case (op)
        OP_REGISTER: begin
          r.status = ST_FULL;
          for (i = 0; i < SLOTS; i++) begin
            cand = next_handle + HANDLE_BITS'(i);
            idx = int'(cand % SLOTS);
            if (!used[idx]) begin
              used[idx] = 1'b1;
              stored_handle[idx] = cand;
              stored_payload[idx] = pay;
              next_handle = cand + HANDLE_BITS'(1);
              occupied++;
              r.handle = {harbor, cand};
              r.status = ST_OK;
              break;
            end
          end
          if (r.status == ST_FULL) full_count++;
        end
        OP_RETIRE, OP_GRAB: begin
          idx = int'(h[HANDLE_BITS-1:0] % SLOTS);
          if (used[idx] && {harbor, stored_handle[idx]} == h) begin
            r.payload = stored_payload[idx];
            if (op == OP_RETIRE) begin
              used[idx] = 1'b0;
              occupied--;
            end
          end else begin
            r.status = ST_NOT_FOUND;
            miss_count++;
          end
        end
        default: begin
          for (i = 0; i < SLOTS; i++) begin
            if (used[i]) begin
              used[i] = 1'b0;
              if (r.count != COUNT_MAX) r.count++;
            end
          end
          occupied = 0;
        end
      endcase
      replies_due.push_back(r);
    endfunction

    function void check_reply(logic [1:0] st, logic [WORD_BITS-1:0] hout,
                              logic [WORD_BITS-1:0] pout, logic [COUNT_BITS-1:0] cnt);
      reply_t e;
      if (replies_due.size() == 0) begin
        $error("result word with none expected: status %0d handle %h", st, hout);
        errors++;
        return;
      end
      e = replies_due.pop_front();
      checked++;
      if (st !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, st);
        errors++;
      end
      if (hout !== e.handle) begin
        $error("handle_out: expected %h, actual %h", e.handle, hout);
        errors++;
      end
      if (pout !== e.payload) begin
        $error("payload_out: expected %h, actual %h", e.payload, pout);
        errors++;
      end
      if (cnt !== e.count) begin
        $error("retired_count: expected %0d, actual %0d", e.count, cnt);
        errors++;
      end
    endfunction

    // walk from a random slot to the first occupied one
    function bit pick_live(output logic [HANDLE_BITS-1:0] h24);
      int base;
      int n;
      int idx;
      base = $urandom_range(0, SLOTS - 1);
      h24 = '0;
      for (n = 0; n < SLOTS; n++) begin
        idx = (base + n) % SLOTS;
        if (used[idx]) begin
          h24 = stored_handle[idx];
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic                   harbor_id_wr;
  logic [HARBOR_BITS-1:0] harbor_id;
  logic [1:0]             operation;
  logic [WORD_BITS-1:0]   handle_in;
  logic [WORD_BITS-1:0]   payload_in;
  logic                   done;
  logic [1:0]             status;
  logic [WORD_BITS-1:0]   handle_out;
  logic [WORD_BITS-1:0]   payload_out;
  logic [COUNT_BITS-1:0]  retired_count;

  handle_table_shadow shadow;
  bit                 gaps_on;

  handle_slot_table uut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .harbor_id_wr  (harbor_id_wr),
    .harbor_id     (harbor_id),
    .operation     (operation),
    .handle_in     (handle_in),
    .payload_in    (payload_in),
    .done          (done),
    .status        (status),
    .handle_out    (handle_out),
    .payload_out   (payload_out),
    .retired_count (retired_count)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done) shadow.check_reply(status, handle_out, payload_out, retired_count);
  end

  // start stays high between back-to-back words; it drops only for gaps and drains
  task automatic send_word(input logic [1:0] op, input logic [WORD_BITS-1:0] h,
                           input logic [WORD_BITS-1:0] pay);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    start <= 1'b1;
    operation <= op;
    handle_in <= h;
    payload_in <= pay;
    do @(posedge clk); while (busy);
    shadow.accept_request(op, h, pay);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (shadow.replies_due.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic set_harbor(input logic [HARBOR_BITS-1:0] v);
    drain();
    harbor_id_wr <= 1'b1;
    harbor_id <= v;
    @(posedge clk);
    harbor_id_wr <= 1'b0;
    harbor_id <= HARBOR_BITS'($urandom);
    shadow.load_harbor(v);
  endtask

  // retire or grab: mostly live handles, some with a wrong harbor byte or upper bits, some random
  task automatic random_lookup(input logic [1:0] op);
    logic [HANDLE_BITS-1:0] h24;
    logic [WORD_BITS-1:0]   h;
    int                     k;
    k = $urandom_range(0, 9);
    h = $urandom;
    if (shadow.pick_live(h24)) begin
      if (k < 6) h = {shadow.harbor, h24};
      else if (k == 6) h = {shadow.harbor ^ HARBOR_BITS'($urandom_range(1, 255)), h24};
      else if (k == 7) h = {shadow.harbor, h24 + HANDLE_BITS'(SLOTS)};
    end
    send_word(op, h, $urandom);
  endtask

  initial begin
    #20ms;
    $display("** handle_slot_table: FAILED **");
    $finish;
  end

  initial begin
    logic [HANDLE_BITS-1:0] h24;
    logic [HARBOR_BITS-1:0] settings [5];
    int                     p;
    int                     n;
    int                     k;
    shadow = new();
    rst = 1'b1;
    start = 1'b0;
    harbor_id_wr = 1'b0;
    harbor_id = '0;
    operation = OP_REGISTER;
    handle_in = '0;
    payload_in = '0;
    gaps_on = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // empty table, reset harbor byte
    send_word(OP_GRAB, 32'h0000_0000, 32'h0);
    send_word(OP_RETIRE, 32'hffff_ffff, 32'hffff_ffff);
    send_word(OP_RETIRE_ALL, 32'h0, 32'h0);
    send_word(OP_REGISTER, 32'h0, 32'h0000_0000);
    send_word(OP_REGISTER, 32'hffff_ffff, 32'hffff_ffff);
    send_word(OP_REGISTER, 32'h0, 32'ha5a5_a5a5);
    send_word(OP_GRAB, 32'h0000_0001, 32'h0);
    send_word(OP_GRAB, 32'h0000_0002, 32'h0);
    send_word(OP_GRAB, 32'h0100_0001, 32'h0);
    send_word(OP_GRAB, 32'h0000_0001 + SLOTS, 32'h0);
    send_word(OP_RETIRE, 32'h0000_0002, 32'h0);
    send_word(OP_RETIRE, 32'h0000_0002, 32'h0);
    send_word(OP_GRAB, 32'h0000_0002, 32'h0);
    send_word(OP_REGISTER, 32'h0, 32'h5a5a_5a5a);
    send_word(OP_RETIRE_ALL, 32'hffff_ffff, 32'hffff_ffff);
    send_word(OP_GRAB, 32'h0000_0001, 32'h0);

    set_harbor(8'hff);
    send_word(OP_REGISTER, 32'h0, 32'h1234_5678);
    send_word(OP_GRAB, 32'hff00_0005, 32'h0);
    send_word(OP_GRAB, 32'h0000_0005, 32'h0);
    send_word(OP_RETIRE, 32'hff00_0005, 32'h0);
    send_word(OP_RETIRE, 32'hff00_0005, 32'h0);

    settings[0] = 8'h00;
    settings[1] = HARBOR_BITS'($urandom);
    settings[2] = 8'hff;
    settings[3] = HARBOR_BITS'($urandom);
    settings[4] = HARBOR_BITS'($urandom);
    for (p = 0; p < 5; p++) begin
      set_harbor(settings[p]);
      gaps_on = (p != 2);
      for (n = 0; n < 120; n++) begin
        k = $urandom_range(0, 99);
        if (k < 45) send_word(OP_REGISTER, $urandom, $urandom);
        else if (k < 65) random_lookup(OP_RETIRE);
        else if (k < 97) random_lookup(OP_GRAB);
        else send_word(OP_RETIRE_ALL, $urandom, $urandom);
      end
    end

    // last part, no gaps: fill the table, run into full, four times free one slot and scan for it, then retire all
    set_harbor(HARBOR_BITS'($urandom));
    gaps_on = 1'b0;
    while (shadow.occupied < SLOTS) begin
      k = $urandom_range(0, 99);
      if (k < 94) send_word(OP_REGISTER, $urandom, $urandom);
      else random_lookup(k < 97 ? OP_RETIRE : OP_GRAB);
    end
    repeat (3) send_word(OP_REGISTER, $urandom, $urandom);
    for (n = 0; n < 4; n++) begin
      void'(shadow.pick_live(h24));
      send_word(OP_GRAB, {shadow.harbor, h24}, $urandom);
      send_word(OP_RETIRE, {shadow.harbor, h24}, $urandom);
      send_word(OP_REGISTER, $urandom, $urandom);
      send_word(OP_REGISTER, $urandom, $urandom);
    end
    send_word(OP_RETIRE_ALL, $urandom, $urandom);
    send_word(OP_REGISTER, $urandom, $urandom);
    send_word(OP_RETIRE_ALL, $urandom, $urandom);

    drain();
    repeat (40) @(posedge clk);
    $display("covered %0d words: %0d register (%0d on a full table), %0d retire, %0d grab,",
             shadow.checked, shadow.op_count[OP_REGISTER], shadow.full_count,
             shadow.op_count[OP_RETIRE], shadow.op_count[OP_GRAB]);
    $display("  %0d retire_all, %0d lookups that missed, %0d mismatches",
             shadow.op_count[OP_RETIRE_ALL], shadow.miss_count, shadow.errors);
    if (shadow.errors == 0) begin
      $display("** handle_slot_table: PASSED **");
    end else begin
      $display("** handle_slot_table: FAILED **");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/hst_pkg.sv
src/hst_ctrl.sv
src/hst_dpath.sv
src/handle_slot_table.sv
tb/tb_handle_slot_table.sv
